// File: rtl/core/pgfv_pkg.sv
package pgfv_pkg;

   // Number format and axis count
   localparam int FRAC_BITS = 16;
   localparam int AXES      = 3;

   // Widths of the datapath
   localparam int COORD_W = 32;              // coordinates, centre, peak, result
   localparam int RAD_W   = 31;              // radius and periods
   localparam int DIFF_W  = 34;              // signed offset after wrapping
   localparam int MAG_W   = 34;              // absolute offset
   localparam int QUO_W   = 31;              // ratio offset/radius in Q28
   localparam int SQ_W    = 33;              // half square of the ratio, Q28
   localparam int Y_W     = 30;              // fractional exponent times ln2, Q30
   localparam int N_W     = 6;               // integer part of the base-2 exponent
   localparam int P_W     = 31;              // exponential in Q30, up to one
   localparam int CSR_IDX_W = 3;

   localparam int EXP_TERMS = 12;

   localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
   localparam logic [29:0] LN2_Q30   = 30'd744261118;
   localparam logic [P_W-1:0] ONE_Q30 = P_W'(1) << 30;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [RAD_W-1:0]          rad_type;
   typedef logic [MAG_W-1:0]          mag_type;
   typedef logic [QUO_W-1:0]          quo_type;
   typedef logic [P_W-1:0]            gain_type;

   // Sideband that travels with each item through the exponential terms
   typedef struct packed {
      logic           zero;
      logic [N_W-1:0] n;
      logic [Y_W-1:0] y;
   } exp_side_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTRE_X    = 3'd0,
      CSR_CENTRE_Y    = 3'd1,
      CSR_CENTRE_Z    = 3'd2,
      CSR_BUMP_RADIUS = 3'd3,
      CSR_PEAK        = 3'd4,
      CSR_PERIOD_X    = 3'd5,
      CSR_PERIOD_Y    = 3'd6,
      CSR_PERIOD_Z    = 3'd7
   } csr_index_type;

endpackage

// File: rtl/core/pgfv_offset.sv
module pgfv_offset (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  pgfv_pkg::coord_type point  [pgfv_pkg::AXES],
   input  pgfv_pkg::coord_type centre [pgfv_pkg::AXES],
   input  pgfv_pkg::rad_type   period [pgfv_pkg::AXES],
   input  pgfv_pkg::rad_type   r_eff,
   output logic                out_valid,
   output logic                out_zero,
   output pgfv_pkg::mag_type   mag    [pgfv_pkg::AXES]
);
   import pgfv_pkg::*;

   logic                     v1_ff, v2_ff, v3_ff;
   logic signed [DIFF_W-1:0] diff_ff [AXES];
   logic signed [DIFF_W-1:0] diff_in [AXES];
   logic signed [DIFF_W-1:0] wrap_ff [AXES];
   logic signed [DIFF_W-1:0] wrap_in [AXES];
   mag_type                  mag_ff  [AXES];
   mag_type                  mag_in  [AXES];
   logic [AXES-1:0]          far;
   logic                     zero_ff;
   logic                     zero_in;

   // Offset, wrap once by the period, then magnitude and far test
   always_comb begin
      logic signed [DIFF_W-1:0] twice;
      logic signed [DIFF_W-1:0] per;
      for (int i = 0; i < AXES; i++) begin
         diff_in[i] = DIFF_W'(point[i]) - DIFF_W'(centre[i]);
         twice = diff_ff[i] <<< 1;
         per   = $signed({{(DIFF_W-RAD_W){1'b0}}, period[i]});
         if (per != '0 && twice > per) begin
            wrap_in[i] = diff_ff[i] - per;
         end else if (per != '0 && twice < -per) begin
            wrap_in[i] = diff_ff[i] + per;
         end else begin
            wrap_in[i] = diff_ff[i];
         end
         mag_in[i] = wrap_ff[i][DIFF_W-1] ? mag_type'(-wrap_ff[i]) : mag_type'(wrap_ff[i]);
         far[i]    = mag_in[i] >= {r_eff, 3'b000};
      end
      zero_in = |far;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         diff_ff <= diff_in;
         wrap_ff <= wrap_in;
         mag_ff  <= mag_in;
         zero_ff <= zero_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_zero  = zero_ff;
   assign mag       = mag_ff;

endmodule

// File: rtl/core/pgfv_divider.sv
module pgfv_divider (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic              in_zero,
   input  pgfv_pkg::mag_type mag [pgfv_pkg::AXES],
   input  pgfv_pkg::rad_type r_eff,
   output logic              out_valid,
   output logic              out_zero,
   output pgfv_pkg::quo_type quo [pgfv_pkg::AXES]
);
   import pgfv_pkg::*;

   // One quotient bit per stage, all three axes side by side
   logic          valid_ff [1:QUO_W];
   logic          zero_ff  [1:QUO_W];
   rad_type       rem_ff   [1:QUO_W-1][AXES];
   logic [2:0]    num_ff   [1:QUO_W-1][AXES];
   quo_type       quo_ff   [1:QUO_W][AXES];

   genvar k, i;
   for (k = 0; k < QUO_W; k++) begin : g_step
      logic       src_valid;
      logic       src_zero;
      rad_type    src_rem [AXES];
      logic [2:0] src_num [AXES];
      quo_type    src_quo [AXES];

      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_zero  = in_zero;
         for (i = 0; i < AXES; i++) begin : g_load
            // the offset times 2^28 starts with its top bits as remainder
            assign src_rem[i] = mag[i][MAG_W-1:3];
            assign src_num[i] = mag[i][2:0];
            assign src_quo[i] = '0;
         end
      end else begin : g_next
         assign src_valid = valid_ff[k];
         assign src_zero  = zero_ff[k];
         for (i = 0; i < AXES; i++) begin : g_load
            assign src_rem[i] = rem_ff[k][i];
            assign src_num[i] = num_ff[k][i];
            assign src_quo[i] = quo_ff[k][i];
         end
      end

      for (i = 0; i < AXES; i++) begin : g_axis
         logic [RAD_W:0] trial;
         logic           ge;
         assign trial = {src_rem[i], src_num[i][2]};
         assign ge    = trial >= {1'b0, r_eff};

         always_ff @(posedge clock) begin
            if (en) begin
               quo_ff[k+1][i] <= {src_quo[i][QUO_W-2:0], ge};
            end
         end

         if (k < QUO_W - 1) begin : g_rem
            always_ff @(posedge clock) begin
               if (en) begin
                  rem_ff[k+1][i] <= ge ? RAD_W'(trial - {1'b0, r_eff}) : trial[RAD_W-1:0];
                  num_ff[k+1][i] <= {src_num[i][1:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[k+1] <= src_zero;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            valid_ff[k+1] <= src_valid;
         end
      end
   end

   assign out_valid = valid_ff[QUO_W];
   assign out_zero  = zero_ff[QUO_W];
   assign quo       = quo_ff[QUO_W];

endmodule

// File: rtl/core/pgfv_exp.sv
module pgfv_exp (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic               in_zero,
   input  pgfv_pkg::quo_type  ratio [pgfv_pkg::AXES],
   output logic               out_valid,
   output pgfv_pkg::gain_type gain
);
   import pgfv_pkg::*;

   logic             v1_ff, v2_ff, v3_ff, v4_ff;
   logic             z1_ff, z2_ff, z3_ff;
   logic [SQ_W-1:0]  sq_ff [AXES];
   logic [SQ_W-1:0]  e_ff;
   logic [N_W-1:0]   n3_ff;
   logic [27:0]      f3_ff;
   exp_side_type     side4_ff;

   logic [2*QUO_W-1:0] sq_full [AXES];
   logic [SQ_W+1:0]    e_sum;
   logic [63:0]        v_full;
   logic [57:0]        y_full;

   // Half squares, their sum, then scale to base 2 and split
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         sq_full[i] = (2*QUO_W)'(ratio[i]) * (2*QUO_W)'(ratio[i]);
      end
      e_sum = (SQ_W+2)'(sq_ff[0]) + (SQ_W+2)'(sq_ff[1]) + (SQ_W+2)'(sq_ff[2]);
      v_full = 64'(e_ff) * 64'(LOG2E_Q30);
      y_full = 58'(f3_ff) * 58'(LN2_Q30);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < AXES; i++) begin
            sq_ff[i] <= sq_full[i][2*QUO_W-1:29];
         end
         z1_ff         <= in_zero;
         e_ff          <= e_sum[SQ_W-1:0];
         z2_ff         <= z1_ff | (|e_sum[SQ_W+1:SQ_W]);
         n3_ff         <= v_full[63:58];
         f3_ff         <= v_full[57:30];
         z3_ff         <= z2_ff;
         side4_ff.zero <= z3_ff;
         side4_ff.n    <= n3_ff;
         side4_ff.y    <= y_full[57:28];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // Series for exp(-y), innermost term first, three stages a term
   logic             va_ff [EXP_TERMS];
   logic             vb_ff [EXP_TERMS];
   logic             vc_ff [EXP_TERMS];
   exp_side_type     sa_ff [EXP_TERMS];
   exp_side_type     sb_ff [EXP_TERMS];
   exp_side_type     sc_ff [EXP_TERMS];
   logic [Y_W-1:0]   ta_ff [EXP_TERMS];
   logic [Y_W-1:0]   tb_ff [EXP_TERMS];
   logic [Y_W-1:0]   qb_ff [EXP_TERMS];
   gain_type         pc_ff [EXP_TERMS];

   genvar j;
   for (j = 0; j < EXP_TERMS; j++) begin : g_term
      localparam int unsigned K = EXP_TERMS - j;
      localparam logic [32:0] RECIP = 33'((64'd1 << 32) / K);

      logic           src_valid;
      exp_side_type   src_side;
      gain_type       src_p;
      logic [60:0]    ta_full;
      logic [62:0]    qb_full;
      logic [33:0]    rem;
      logic [Y_W-1:0] q_fix;

      if (j == 0) begin : g_first
         assign src_valid = v4_ff;
         assign src_side  = side4_ff;
         assign src_p     = ONE_Q30;
      end else begin : g_next
         assign src_valid = vc_ff[j-1];
         assign src_side  = sc_ff[j-1];
         assign src_p     = pc_ff[j-1];
      end

      // product, quotient by reciprocal, then one correction step
      assign ta_full = 61'(src_side.y) * 61'(src_p);
      assign qb_full = 63'(ta_ff[j]) * 63'(RECIP);
      assign rem     = 34'(tb_ff[j]) - 34'(qb_ff[j]) * 34'(K);
      assign q_fix   = qb_ff[j] + Y_W'(rem >= 34'(K));

      always_ff @(posedge clock) begin
         if (en) begin
            ta_ff[j] <= ta_full[59:30];
            sa_ff[j] <= src_side;
            qb_ff[j] <= qb_full[61:32];
            tb_ff[j] <= ta_ff[j];
            sb_ff[j] <= sa_ff[j];
            pc_ff[j] <= ONE_Q30 - P_W'(q_fix);
            sc_ff[j] <= sb_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            va_ff[j] <= 1'b0;
            vb_ff[j] <= 1'b0;
            vc_ff[j] <= 1'b0;
         end else if (en) begin
            va_ff[j] <= src_valid;
            vb_ff[j] <= va_ff[j];
            vc_ff[j] <= vb_ff[j];
         end
      end
   end

   // Apply the integer part of the exponent as a right shift
   logic     vg_ff;
   gain_type gain_ff;
   gain_type gain_in;

   always_comb begin
      if (sc_ff[EXP_TERMS-1].zero || sc_ff[EXP_TERMS-1].n >= N_W'(31)) begin
         gain_in = '0;
      end else begin
         gain_in = pc_ff[EXP_TERMS-1] >> sc_ff[EXP_TERMS-1].n[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         gain_ff <= gain_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vg_ff <= 1'b0;
      end else if (en) begin
         vg_ff <= vc_ff[EXP_TERMS-1];
      end
   end

   assign out_valid = vg_ff;
   assign gain      = gain_ff;

endmodule

// File: rtl/core/periodic_gaussian_field_value.sv
// Periodic Gaussian field value.
// Each point on the req channel (cell x, y, z, signed fixed point) gives one
// rsp item: peak * exp(-|d|^2 / (2 radius^2)), d the offset from the centre,
// wrapped once per axis that has a nonzero period, rounded and saturated.
// The csr channel writes the centre, radius, peak and periods by index; it is
// always ready and is to be written only while no point is in flight; the
// block itself does not enforce this. Throughput is one point per cycle
// while rsp_tready does not stall the pipeline. A point passes the offset
// and wrap, the bit-a-stage ratio divider, the squares, base-2 scaling and
// twelve three-stage series terms and the peak multiply and output register.
// The whole pipeline advances together; when the receiver holds rsp_tready
// low with a result waiting, req_tready drops and every stage holds, so
// nothing is lost or repeated. Reset empties the pipeline and returns the
// registers to centre zero, radius one, peak zero and no wrapping.
module periodic_gaussian_field_value (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [3*pgfv_pkg::COORD_W-1:0]  req_tdata,   // cell_x, cell_y, cell_z
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [pgfv_pkg::COORD_W-1:0]    rsp_tdata,   // field_value
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pgfv_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pgfv_pkg::COORD_W-1:0]    csr_data
);
   import pgfv_pkg::*;

   coord_type centre_ff [AXES];
   rad_type   period_ff [AXES];
   rad_type   radius_ff;
   coord_type peak_ff;
   rad_type   r_eff;

   // Register writes; every index of the channel names a register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXES; i++) begin
            centre_ff[i] <= '0;
            period_ff[i] <= '0;
         end
         radius_ff <= RAD_W'(1) << FRAC_BITS;
         peak_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_CENTRE_X:    centre_ff[0] <= csr_data;
            CSR_CENTRE_Y:    centre_ff[1] <= csr_data;
            CSR_CENTRE_Z:    centre_ff[2] <= csr_data;
            CSR_BUMP_RADIUS: radius_ff    <= csr_data[RAD_W-1:0];
            CSR_PEAK:        peak_ff      <= csr_data;
            CSR_PERIOD_X:    period_ff[0] <= csr_data[RAD_W-1:0];
            CSR_PERIOD_Y:    period_ff[1] <= csr_data[RAD_W-1:0];
            CSR_PERIOD_Z:    period_ff[2] <= csr_data[RAD_W-1:0];
            default: ;
         endcase
      end
   end

   // A zero radius counts as one LSB
   assign r_eff = (radius_ff == '0) ? RAD_W'(1) : radius_ff;

   // Advance every stage when the output register is free or being taken
   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   coord_type point [AXES];
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         point[i] = req_tdata[i*COORD_W +: COORD_W];
      end
   end

   logic    off_valid, off_zero;
   mag_type off_mag [AXES];

   pgfv_offset u_offset (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid && req_tready),
      .point     (point),
      .centre    (centre_ff),
      .period    (period_ff),
      .r_eff     (r_eff),
      .out_valid (off_valid),
      .out_zero  (off_zero),
      .mag       (off_mag)
   );

   logic    div_valid, div_zero;
   quo_type div_quo [AXES];

   pgfv_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (off_valid),
      .in_zero   (off_zero),
      .mag       (off_mag),
      .r_eff     (r_eff),
      .out_valid (div_valid),
      .out_zero  (div_zero),
      .quo       (div_quo)
   );

   logic     exp_valid;
   gain_type exp_gain;

   pgfv_exp u_exp (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_valid),
      .in_zero   (div_zero),
      .ratio     (div_quo),
      .out_valid (exp_valid),
      .gain      (exp_gain)
   );

   // Scale the peak magnitude by the gain
   logic [COORD_W-1:0] peak_mag;
   logic [62:0]        prod_ff;
   logic [62:0]        prod_in;
   logic               pv_ff;

   assign peak_mag = peak_ff[COORD_W-1] ? COORD_W'(-peak_ff) : COORD_W'(peak_ff);
   assign prod_in  = 63'(peak_mag) * 63'(exp_gain);

   // Round, restore the sign and saturate
   logic [32:0]        q_round;
   logic [COORD_W-1:0] q_mag;
   logic [COORD_W-1:0] rsp_data_ff;
   logic [COORD_W-1:0] rsp_data_in;
   logic               rsp_valid_ff;

   always_comb begin
      q_round = 33'((prod_ff + (63'(1) << 29)) >> 30);
      q_mag   = q_round[COORD_W-1:0];
      if (peak_ff[COORD_W-1]) begin
         rsp_data_in = COORD_W'(-q_mag);
      end else if (q_round[COORD_W] || q_round[COORD_W-1]) begin
         rsp_data_in = {1'b0, {(COORD_W-1){1'b1}}};
      end else begin
         rsp_data_in = q_mag;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff     <= prod_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         pv_ff        <= exp_valid;
         rsp_valid_ff <= pv_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The gain never exceeds one in Q30
   assert property (@(posedge clock) disable iff (reset)
      exp_valid |-> exp_gain <= ONE_Q30)
      else $error("gain above one");

   // A zero peak gives a zero result
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && peak_ff == '0) |-> rsp_tdata == '0)
      else $error("nonzero result with zero peak");

   // The result carries the sign of the peak
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !peak_ff[COORD_W-1]) |-> !rsp_tdata[COORD_W-1])
      else $error("negative result with positive peak");

   // A stalled result stays valid, and so does the product stage before it
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready && pv_ff) |=> pv_ff && rsp_tvalid)
      else $error("pipeline advanced under stall");

endmodule
